/* rtl/core/lgs_pkg.sv */
// ============================================================================
// Life generation stencil: shared package
// Types, constants and the B3/S23 rule shared by the stencil unit modules.
// ============================================================================
package lgs_pkg;

    // Neighbor counts of the B3/S23 rule.
    localparam int unsigned BIRTH_COUNT = 3;
    localparam int unsigned STAY_COUNT  = 2;

    // Width of a neighbor count (0 to 8).
    localparam int unsigned NBR_CNT_W = 4;

    // Width of the row and column fields of a result.
    localparam int unsigned COORD_OUT_W = 5;

    // Sequencer states: taking cells, or draining the last results of a frame.
    typedef enum logic
    {
        ST_RUN,
        ST_FLUSH
    } ctrl_state_t;

    // One column of the 3x3 window: three vertically adjacent cells.
    typedef struct packed
    {
        logic top;
        logic mid;
        logic bot;
    } column_t;

    // Which sides of the reported cell lie inside the grid.
    typedef struct packed
    {
        logic has_top;
        logic has_bot;
        logic has_left;
        logic has_right;
    } border_t;

    // One result item.
    typedef struct packed
    {
        logic                   frame_done;
        logic                   run_last;
        logic [COORD_OUT_W-1:0] cell_col;
        logic [COORD_OUT_W-1:0] cell_row;
        logic                   next_alive;
    } result_t;

    // Next state of a cell from its own state and its live neighbor count.
    function automatic logic life_rule(input logic alive, input logic [NBR_CNT_W-1:0] count);
        return (count == NBR_CNT_W'(BIRTH_COUNT)) ||
               (alive && (count == NBR_CNT_W'(STAY_COUNT)));
    endfunction

endpackage

/* rtl/core/lgs_line_mem.sv */
// ============================================================================
// Line memory
// One entry per column holding the cells of the two rows above the current
// one. Synchronous, registered read; a write to the address being read in
// the same cycle is forwarded to the read data.
// ============================================================================
module lgs_line_mem #(
    parameter  int unsigned DEPTH = 32,
    localparam int unsigned AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [1:0]    wr_data,   // bit 1: two rows up, bit 0: one row up
    input  logic [AW-1:0] rd_addr,
    output logic [1:0]    rd_data
);

    logic [1:0] mem [DEPTH];
    logic [1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port with write-to-read forwarding.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/lgs_window.sv */
// ============================================================================
// Stencil window
// Holds the left and center columns of the 3x3 window; the arriving column
// is the right one. Counts live neighbors inside the grid and applies B3/S23.
// ============================================================================
module lgs_window (
    input  logic             clk,
    input  logic             step,
    input  lgs_pkg::column_t right_col,
    input  lgs_pkg::border_t border,
    output logic             next_alive
);

    lgs_pkg::column_t                  left_reg;
    lgs_pkg::column_t                  ctr_reg;
    logic [lgs_pkg::NBR_CNT_W-1:0]     nbr_count;

    // Shift the window one column on every step.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            left_reg <= ctr_reg;
            ctr_reg  <= right_col;
        end
    end

    // Live neighbors, with cells beyond the border counted as dead.
    always_comb
    begin
        nbr_count =
            lgs_pkg::NBR_CNT_W'(left_reg.top & border.has_left & border.has_top) +
            lgs_pkg::NBR_CNT_W'(left_reg.mid & border.has_left) +
            lgs_pkg::NBR_CNT_W'(left_reg.bot & border.has_left & border.has_bot) +
            lgs_pkg::NBR_CNT_W'(ctr_reg.top & border.has_top) +
            lgs_pkg::NBR_CNT_W'(ctr_reg.bot & border.has_bot) +
            lgs_pkg::NBR_CNT_W'(right_col.top & border.has_right & border.has_top) +
            lgs_pkg::NBR_CNT_W'(right_col.mid & border.has_right) +
            lgs_pkg::NBR_CNT_W'(right_col.bot & border.has_right & border.has_bot);
    end

    assign next_alive = lgs_pkg::life_rule(ctr_reg.mid, nbr_count);

endmodule

/* rtl/core/lgs_out_fifo.sv */
// ============================================================================
// Output buffer
// Two-entry result queue. Its space flag comes from a register, so the input
// side never waits combinationally on the output ready.
// ============================================================================
module lgs_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lgs_pkg::result_t push_data,
    output logic             not_full,
    output logic             out_valid,
    input  logic             out_ready,
    output lgs_pkg::result_t out_data
);

    lgs_pkg::result_t ent0_reg;
    lgs_pkg::result_t ent1_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign not_full  = (count_reg != 2'd2);
    assign out_data  = ent0_reg;

    // Occupancy.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Entry storage: entry 0 is the head.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (push && (count_reg == 2'd1))
            begin
                ent0_reg <= push_data;
            end
            else
            begin
                ent0_reg <= ent1_reg;
            end
            if (push && (count_reg == 2'd2))
            begin
                ent1_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                ent0_reg <= push_data;
            end
            else
            begin
                ent1_reg <= push_data;
            end
        end
    end

`ifndef SYNTHESIS
    // The queue never holds more than two results.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("output queue occupancy out of range");

    // A full queue never takes a new result.
    assert property (@(posedge clk) disable iff (!rst_n) (count_reg == 2'd2) |-> !push)
        else $error("result pushed into a full output queue");
`endif

endmodule

/* rtl/core/life_generation_stencil_unit.sv */
// ============================================================================
// Life generation stencil unit
// Streams one generation of a square Game of Life grid and returns the next.
// ============================================================================
// The unit takes one cell per cycle in raster order, while its output queue
// has space, and returns the next B3/S23 state of each cell, with its row and
// column, through a two-entry output queue; cells beyond the grid edge count
// as dead. The result for a cell is pushed into the queue in the same cycle
// as the cell one row and one column past it is accepted. After the final
// cell of a frame the unit drains the last S+1 results (S being the side) at
// one per cycle while the queue has space and holds off input until the
// drain ends, when S is 2 or more; a side of 1 needs no drain. The two rows
// above the current one live in a line memory of MAX_SIDE two-bit entries,
// read one column ahead and written back on every step; it needs no clearing
// pass, since its stale content only ever feeds cells beyond the grid edge.
// Writing side_length restarts the frame.
// ============================================================================
module life_generation_stencil_unit #(
    parameter int unsigned MAX_SIDE = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Cell input.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] cell_alive
    // Result output.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] next_alive, [5:1] cell_row, [10:6] cell_col
    output logic        m_axis_tlast,   // run_last
    output logic        m_axis_tuser,   // [0] frame_done
    // Side length register write.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data        // side_length
);

    localparam int unsigned CW         = $clog2(MAX_SIDE);
    localparam int unsigned SW         = $clog2(MAX_SIDE + 1);
    localparam int unsigned SIDE_RESET = (MAX_SIDE < 32) ? MAX_SIDE : 32;

    lgs_pkg::ctrl_state_t state_reg;
    lgs_pkg::ctrl_state_t state_next;
    logic [CW-1:0]        side_m1_reg;
    logic [CW-1:0]        side_m1_next;
    logic [CW-1:0]        in_row_reg;
    logic [CW-1:0]        in_row_next;
    logic [CW-1:0]        in_col_reg;
    logic [CW-1:0]        in_col_next;
    logic [CW-1:0]        out_row_reg;
    logic [CW-1:0]        out_row_next;
    logic [CW-1:0]        out_col_reg;
    logic [CW-1:0]        out_col_next;
    logic [SW-1:0]        flush_cnt_reg;
    logic [SW-1:0]        flush_cnt_next;

    logic                 cfg_fire;
    logic                 in_fire;
    logic [CW-1:0]        cfg_side_m1;
    logic                 in_last_col;
    logic                 final_cell;
    logic                 side_one;
    logic                 step;
    logic                 cell_bit;
    logic                 emit;
    logic                 run_last;
    logic                 frame_end;
    logic                 fifo_not_full;
    logic [1:0]           line_rd;
    lgs_pkg::column_t     new_col;
    lgs_pkg::border_t     border;
    logic                 next_alive;
    lgs_pkg::result_t     result;
    lgs_pkg::result_t     head;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    // Effective side of a written value, kept as side minus one.
    always_comb
    begin
        if (cfg_data == 6'd0)
        begin
            cfg_side_m1 = '0;
        end
        else if (cfg_data > 6'(MAX_SIDE))
        begin
            cfg_side_m1 = CW'(MAX_SIDE - 1);
        end
        else
        begin
            cfg_side_m1 = CW'(cfg_data - 6'd1);
        end
    end

    assign in_last_col = (in_col_reg == side_m1_reg);
    assign final_cell  = (in_row_reg == side_m1_reg) && in_last_col;
    assign side_one    = (side_m1_reg == '0);

    // Step sequencer: real cells while running, blank cells while draining.
    always_comb
    begin
        state_next     = state_reg;
        side_m1_next   = side_m1_reg;
        in_row_next    = in_row_reg;
        in_col_next    = in_col_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        flush_cnt_next = flush_cnt_reg;
        s_axis_tready  = 1'b0;
        step           = 1'b0;
        cell_bit       = 1'b0;
        emit           = 1'b0;
        run_last       = 1'b1;
        frame_end      = 1'b0;

        case (state_reg)
            lgs_pkg::ST_RUN:
            begin
                s_axis_tready = fifo_not_full;
                step          = in_fire;
                cell_bit      = s_axis_tdata[0];
                // A result is due once the cell one row and one column past it is here.
                emit = in_fire && (final_cell ||
                       ((in_row_reg != '0) && !((in_row_reg == CW'(1)) && (in_col_reg == '0))));
                run_last  = !final_cell || side_one;
                frame_end = in_fire && final_cell && side_one;
                if (in_fire)
                begin
                    if (final_cell)
                    begin
                        in_row_next = '0;
                        if (!side_one)
                        begin
                            state_next     = lgs_pkg::ST_FLUSH;
                            flush_cnt_next = SW'(side_m1_reg) + SW'(1);
                        end
                    end
                    else if (in_last_col)
                    begin
                        in_row_next = in_row_reg + CW'(1);
                    end
                end
            end
            lgs_pkg::ST_FLUSH:
            begin
                step      = fifo_not_full;
                emit      = step;
                run_last  = (flush_cnt_reg == '0);
                frame_end = step && (flush_cnt_reg == '0);
                if (step)
                begin
                    if (flush_cnt_reg == '0)
                    begin
                        state_next = lgs_pkg::ST_RUN;
                    end
                    else
                    begin
                        flush_cnt_next = flush_cnt_reg - SW'(1);
                    end
                end
            end
            default:
            begin
                state_next = lgs_pkg::ST_RUN;
            end
        endcase

        // Input column, which is also the line memory's read-ahead address.
        if (step)
        begin
            if (frame_end || in_last_col)
            begin
                in_col_next = '0;
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
        end

        // Position of the next reported cell.
        if (emit)
        begin
            if (frame_end || (out_col_reg == side_m1_reg))
            begin
                out_col_next = '0;
                out_row_next = frame_end ? '0 : (out_row_reg + CW'(1));
            end
            else
            begin
                out_col_next = out_col_reg + CW'(1);
            end
        end

        // A side write restarts the frame.
        if (cfg_fire)
        begin
            state_next   = lgs_pkg::ST_RUN;
            side_m1_next = cfg_side_m1;
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lgs_pkg::ST_RUN;
            side_m1_reg   <= CW'(SIDE_RESET - 1);
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            flush_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            side_m1_reg   <= side_m1_next;
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            flush_cnt_reg <= flush_cnt_next;
        end
    end

    // Line memory: read the upcoming column, write back the shifted pair.
    lgs_line_mem #(
        .DEPTH (MAX_SIDE)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (step),
        .wr_addr (in_col_reg),
        .wr_data ({line_rd[0], cell_bit}),
        .rd_addr (in_col_next),
        .rd_data (line_rd)
    );

    assign new_col.top = line_rd[1];
    assign new_col.mid = line_rd[0];
    assign new_col.bot = cell_bit;

    // Grid edges around the reported cell.
    assign border.has_top   = (out_row_reg != '0);
    assign border.has_bot   = (out_row_reg != side_m1_reg);
    assign border.has_left  = (out_col_reg != '0);
    assign border.has_right = (out_col_reg != side_m1_reg);

    lgs_window u_window (
        .clk        (clk),
        .step       (step),
        .right_col  (new_col),
        .border     (border),
        .next_alive (next_alive)
    );

    // Result assembly.
    assign result.next_alive = next_alive;
    assign result.cell_row   = lgs_pkg::COORD_OUT_W'(out_row_reg);
    assign result.cell_col   = lgs_pkg::COORD_OUT_W'(out_col_reg);
    assign result.run_last   = run_last;
    assign result.frame_done = (out_row_reg == side_m1_reg) && (out_col_reg == side_m1_reg);

    lgs_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_data (result),
        .not_full  (fifo_not_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head)
    );

    assign m_axis_tdata = {5'd0, head.cell_col, head.cell_row, head.next_alive};
    assign m_axis_tlast = head.run_last;
    assign m_axis_tuser = head.frame_done;

`ifndef SYNTHESIS
    // The frame-end result always closes the run of results of its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && result.frame_done) |-> result.run_last)
        else $error("frame end result not marked as last of its run");

    // The reported position never leaves the grid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_row_reg <= side_m1_reg) && (out_col_reg <= side_m1_reg))
        else $error("reported position outside the grid");

    // Draining starts only right after the final cell of a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == lgs_pkg::ST_FLUSH) && ($past(state_reg) == lgs_pkg::ST_RUN))
        |-> $past(in_fire && final_cell))
        else $error("drain started without a final cell");
`endif

endmodule
